@@ src/dls_pkg.sv @@
// Shared types and constants of the diagonal lifting stencil.
package dls_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RAW_SIZE_W  = 11;

  localparam logic signed [SAMPLE_W-1:0] COEF_UL_RST = 16'sd16384;
  localparam logic signed [SAMPLE_W-1:0] COEF_UR_RST = 16'sd12288;
  localparam logic signed [SAMPLE_W-1:0] COEF_DL_RST = 16'sd12288;
  localparam logic signed [SAMPLE_W-1:0] COEF_DR_RST = 16'sd9216;
  localparam logic [RAW_SIZE_W-1:0]      SIZE_RST    = 11'd1024;

  typedef enum logic [2:0] {
    REG_COEF_UL  = 3'd0,
    REG_COEF_UR  = 3'd1,
    REG_COEF_DL  = 3'd2,
    REG_COEF_DR  = 3'd3,
    REG_ADD_MODE = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] up_left;
    logic signed [SAMPLE_W-1:0] up_right;
    logic signed [SAMPLE_W-1:0] down_left;
    logic signed [SAMPLE_W-1:0] down_right;
    logic                       add_mode;
  } coef_t;

  // One classified item: centre, its four diagonal neighbors and flags.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] up_left;
    logic signed [SAMPLE_W-1:0] up_right;
    logic signed [SAMPLE_W-1:0] down_left;
    logic signed [SAMPLE_W-1:0] down_right;
    logic                       border;
    logic                       last;
  } win_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } res_t;

endpackage

@@ src/dls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2052
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/dls_fifo.sv @@
// Small register-based queue with occupancy count.
module dls_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i & (count_q != '0);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/dls_regs.sv @@
// APB configuration registers: weights, mode and clamped frame geometry.
module dls_regs #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dls_pkg::APB_AW-1:0]             paddr,
  input  logic [dls_pkg::APB_DW-1:0]             pwdata,
  output logic [dls_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready,
  output dls_pkg::coef_t                         coef_o,
  output logic [$clog2(MAX_WIDTH+2)-1:0]         w_o,
  output logic [$clog2(MAX_WIDTH+2)-1:0]         wp1_o,
  output logic [$clog2(MAX_WIDTH+2)-1:0]         wm1_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        h_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        hm1_o
);

  import dls_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int unsigned H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  coef_t                 coef_q;
  logic [RAW_SIZE_W-1:0] w_raw_q, h_raw_q;
  logic [CW-1:0]         w_q, wp1_q, wm1_q;
  logic [RW-1:0]         h_q, hm1_q;
  logic                  wr_en;
  logic [2:0]            idx;
  logic [31:0]           w_new, h_new, raw_new;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // Clamp sizes to 1..max as they are written, so the datapath sees them at once.
  assign raw_new = 32'(pwdata[RAW_SIZE_W-1:0]);
  assign w_new   = (raw_new == 32'd0) ? 32'd1 :
                   (raw_new > MAX_WIDTH) ? 32'(MAX_WIDTH) : raw_new;
  assign h_new   = (raw_new == 32'd0) ? 32'd1 :
                   (raw_new > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : raw_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.up_left    <= COEF_UL_RST;
      coef_q.up_right   <= COEF_UR_RST;
      coef_q.down_left  <= COEF_DL_RST;
      coef_q.down_right <= COEF_DR_RST;
      coef_q.add_mode   <= 1'b0;
      w_raw_q           <= SIZE_RST;
      h_raw_q           <= SIZE_RST;
      w_q               <= CW'(W_RST);
      wp1_q             <= CW'(W_RST + 1);
      wm1_q             <= CW'(W_RST - 1);
      h_q               <= RW'(H_RST);
      hm1_q             <= RW'(H_RST - 1);
    end else if (wr_en) begin
      case (idx)
        REG_COEF_UL:  coef_q.up_left    <= pwdata[SAMPLE_W-1:0];
        REG_COEF_UR:  coef_q.up_right   <= pwdata[SAMPLE_W-1:0];
        REG_COEF_DL:  coef_q.down_left  <= pwdata[SAMPLE_W-1:0];
        REG_COEF_DR:  coef_q.down_right <= pwdata[SAMPLE_W-1:0];
        REG_ADD_MODE: coef_q.add_mode   <= pwdata[0];
        REG_WIDTH: begin
          w_raw_q <= pwdata[RAW_SIZE_W-1:0];
          w_q     <= CW'(w_new);
          wp1_q   <= CW'(w_new + 32'd1);
          wm1_q   <= CW'(w_new - 32'd1);
        end
        REG_HEIGHT: begin
          h_raw_q <= pwdata[RAW_SIZE_W-1:0];
          h_q     <= RW'(h_new);
          hm1_q   <= RW'(h_new - 32'd1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_UL:  prdata = APB_DW'(coef_q.up_left);
      REG_COEF_UR:  prdata = APB_DW'(coef_q.up_right);
      REG_COEF_DL:  prdata = APB_DW'(coef_q.down_left);
      REG_COEF_DR:  prdata = APB_DW'(coef_q.down_right);
      REG_ADD_MODE: prdata = APB_DW'(coef_q.add_mode);
      REG_WIDTH:    prdata = APB_DW'(w_raw_q);
      REG_HEIGHT:   prdata = APB_DW'(h_raw_q);
      default:      prdata = '0;
    endcase
  end

  assign coef_o = coef_q;
  assign w_o    = w_q;
  assign wp1_o  = wp1_q;
  assign wm1_o  = wm1_q;
  assign h_o    = h_q;
  assign hm1_o  = hm1_q;

endmodule

@@ src/dls_front.sv @@
// Front end: stores samples in the line ring, tracks positions, gathers windows.
module dls_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic signed [dls_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 is_flush_i,
  output logic                                 full_o,
  input  logic [$clog2(MAX_WIDTH+2)-1:0]       w_i,
  input  logic [$clog2(MAX_WIDTH+2)-1:0]       wp1_i,
  input  logic [$clog2(MAX_WIDTH+2)-1:0]       wm1_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      hm1_i,
  input  logic [dls_pkg::QCNT_W-1:0]           qcount_i,
  output logic                                 win_valid_o,
  output dls_pkg::win_t                        win_o
);

  import dls_pkg::*;

  localparam int unsigned RING = 2 * MAX_WIDTH + 4;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned CW   = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW   = $clog2(MAX_WIDTH + 3);
  localparam int unsigned NTAP = 5;
  localparam logic [AW:0]   RING_E    = RING[AW:0];
  localparam logic [AW-1:0] RING_LAST = AW'(RING - 1);

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] t;
    t = {1'b0, base} + RING_E - {{(AW + 1 - CW){1'b0}}, off};
    if (t >= RING_E) t = t - RING_E;
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] t;
    t = {1'b0, base} + {{(AW + 1 - CW){1'b0}}, off};
    if (t >= RING_E) t = t - RING_E;
    return t[AW-1:0];
  endfunction

  logic [AW-1:0]       ws_q, ws_d, tail_q, tail_d;
  logic [PW-1:0]       pending_q, pending_d;
  logic [CW-1:0]       col_q, col_d, col_inc;
  logic [RW-1:0]       row_q, row_d, row_inc;
  logic                accept, emit, border, last;
  logic [AW-1:0]       raddr [NTAP];
  logic [NTAP-1:0]     fwd;
  logic [SAMPLE_W-1:0] rdata [NTAP];
  logic signed [SAMPLE_W-1:0] tap [NTAP];

  logic                       s1_v_q;
  logic [NTAP-1:0]            s1_fwd_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_border_q, s1_last_q;

  // Every emitted item lands in the queue the next cycle, so reserve its slot.
  assign full_o = (32'(qcount_i) + 32'(s1_v_q)) >= QUEUE_DEPTH;
  assign accept = push_i & ~full_o;
  assign emit   = accept & (is_flush_i ? (pending_q != '0)
                                       : (32'(pending_q) >= 32'(wp1_i)));

  // Tap order: centre, up-left, up-right, down-left, down-right.
  assign raddr[0] = tail_q;
  assign raddr[1] = ring_sub(tail_q, wp1_i);
  assign raddr[2] = ring_sub(tail_q, wm1_i);
  assign raddr[3] = ring_add(tail_q, wm1_i);
  assign raddr[4] = ring_add(tail_q, wp1_i);

  assign border = (row_q == '0) || (col_q == '0) || (row_q >= hm1_i) || (col_q >= wm1_i);
  assign last   = (row_q >= hm1_i) && (col_q >= wm1_i);

  assign col_inc = col_q + 1'b1;
  assign row_inc = row_q + 1'b1;

  for (genvar k = 0; k < NTAP; k++) begin : g_tap
    // Each tap has its own copy of the ring so all five are read in the same cycle.
    dls_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING)
    ) u_ring (
      .clk_i   (clk_i),
      .we_i    (accept & ~is_flush_i),
      .waddr_i (ws_q),
      .wdata_i (sample_i),
      .re_i    (emit),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
    // Bypass the slot written in the same cycle.
    assign fwd[k] = ~is_flush_i & (raddr[k] == ws_q);
    assign tap[k] = s1_fwd_q[k] ? s1_sample_q : $signed(rdata[k]);
  end

  always_comb begin
    ws_d      = ws_q;
    tail_d    = tail_q;
    pending_d = pending_q;
    col_d     = col_q;
    row_d     = row_q;
    if (accept && !is_flush_i) begin
      ws_d = (ws_q == RING_LAST) ? '0 : ws_q + 1'b1;
    end
    if (accept && !is_flush_i && !emit) begin
      pending_d = pending_q + 1'b1;
    end else if (emit && is_flush_i) begin
      pending_d = pending_q - 1'b1;
    end
    if (emit) begin
      tail_d = (tail_q == RING_LAST) ? '0 : tail_q + 1'b1;
      if (col_inc >= w_i) begin
        col_d = '0;
        row_d = (row_inc >= h_i) ? '0 : row_inc;
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= '0;
      tail_q    <= '0;
      pending_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
    end else begin
      ws_q      <= ws_d;
      tail_q    <= tail_d;
      pending_q <= pending_d;
      col_q     <= col_d;
      row_q     <= row_d;
      s1_v_q    <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_fwd_q    <= fwd;
      s1_sample_q <= sample_i;
      s1_border_q <= border;
      s1_last_q   <= last;
    end
  end

  assign win_valid_o       = s1_v_q;
  assign win_o.centre      = tap[0];
  assign win_o.up_left     = tap[1];
  assign win_o.up_right    = tap[2];
  assign win_o.down_left   = tap[3];
  assign win_o.down_right  = tap[4];
  assign win_o.border      = s1_border_q;
  assign win_o.last        = s1_last_q;

endmodule

@@ src/dls_back.sv @@
// Back end: weighted diagonal sum, lifting add or subtract, rounding, saturation; border pixels pass the centre.
module dls_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dls_pkg::coef_t                      coef_i,
  input  logic                                win_empty_i,
  input  dls_pkg::win_t                       win_i,
  output logic                                win_pop_o,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [dls_pkg::SAMPLE_W-1:0] value_o,
  output logic                                last_of_frame_o
);

  import dls_pkg::*;

  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic [OCW-1:0] ocount;
  logic           credit_ok;
  res_t           a_res, head;

  // Multiply stage.
  logic                       m_v_q;
  logic signed [31:0]         m_p_q [4];
  logic signed [SAMPLE_W-1:0] m_centre_q;
  logic                       m_border_q, m_last_q;

  // Pair-sum stage.
  logic                       s_v_q;
  logic signed [32:0]         s_lo_q, s_hi_q;
  logic signed [34:0]         s_base_q;
  logic signed [SAMPLE_W-1:0] s_centre_q;
  logic                       s_border_q, s_last_q;

  // Result stage.
  logic                       a_v_q;
  logic signed [SAMPLE_W-1:0] a_value_q;
  logic                       a_last_q;

  logic signed [34:0]         sum, total;
  logic signed [20:0]         scaled;
  logic signed [SAMPLE_W-1:0] sat;

  // Only start an item when the output queue can take everything in flight.
  assign credit_ok = (32'(ocount) + 32'(m_v_q) + 32'(s_v_q) + 32'(a_v_q)) < OUT_DEPTH;
  assign win_pop_o = ~win_empty_i & credit_ok;

  assign sum    = 35'(s_lo_q) + 35'(s_hi_q);
  assign total  = coef_i.add_mode ? (s_base_q + sum) : (s_base_q - sum);
  assign scaled = total[34:14];

  always_comb begin
    if (scaled[20:15] == {6{scaled[15]}}) begin
      sat = scaled[15:0];
    end else if (scaled[20]) begin
      sat = 16'sh8000;
    end else begin
      sat = 16'sh7FFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      s_v_q <= 1'b0;
      a_v_q <= 1'b0;
    end else begin
      m_v_q <= win_pop_o;
      s_v_q <= m_v_q;
      a_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_pop_o) begin
      m_p_q[0]   <= 32'($signed(win_i.up_left))    * 32'($signed(coef_i.up_left));
      m_p_q[1]   <= 32'($signed(win_i.up_right))   * 32'($signed(coef_i.up_right));
      m_p_q[2]   <= 32'($signed(win_i.down_left))  * 32'($signed(coef_i.down_left));
      m_p_q[3]   <= 32'($signed(win_i.down_right)) * 32'($signed(coef_i.down_right));
      m_centre_q <= win_i.centre;
      m_border_q <= win_i.border;
      m_last_q   <= win_i.last;
    end
    if (m_v_q) begin
      s_lo_q     <= 33'(m_p_q[0]) + 33'(m_p_q[1]);
      s_hi_q     <= 33'(m_p_q[2]) + 33'(m_p_q[3]);
      // centre in Q.14 plus half an output step for rounding
      s_base_q   <= {{5{m_centre_q[SAMPLE_W-1]}}, m_centre_q, 14'h2000};
      s_centre_q <= m_centre_q;
      s_border_q <= m_border_q;
      s_last_q   <= m_last_q;
    end
    if (s_v_q) begin
      a_value_q <= s_border_q ? s_centre_q : sat;
      a_last_q  <= s_last_q;
    end
  end

  assign a_res.value = a_value_q;
  assign a_res.last  = a_last_q;

  dls_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (a_v_q),
    .wdata_i (a_res),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .count_o (ocount)
  );

  assign value_o         = head.value;
  assign last_of_frame_o = head.last;

endmodule

@@ src/diagonal_lifting_stencil.sv @@
// A pixel's result goes through the ring read, window queue, multiply, pair-sum and
// result stages into the output queue once the item that releases it is accepted;
// a sample releases the pixel width+1 samples back, a flush the oldest pending one.
// Throughput: one item per cycle while full is low, limited by the one-sample write
// and five-tap read of the replicated line-ring RAMs. Reset clears positions, queues
// and registers to defaults; the line ring is not cleared and needs no clearing pass.
module diagonal_lifting_stencil #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dls_pkg::APB_AW-1:0]          paddr,
  input  logic [dls_pkg::APB_DW-1:0]          pwdata,
  output logic [dls_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic signed [dls_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                is_flush_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [dls_pkg::SAMPLE_W-1:0] value_o,
  output logic                                last_of_frame_o
);

  import dls_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  coef_t             coef;
  logic [CW-1:0]     w, wp1, wm1;
  logic [RW-1:0]     h, hm1;
  logic              win_valid, win_pop, win_empty;
  win_t              win_in, win_out;
  logic [QCNT_W-1:0] qcount;

  dls_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .w_o     (w),
    .wp1_o   (wp1),
    .wm1_o   (wm1),
    .h_o     (h),
    .hm1_o   (hm1)
  );

  dls_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .sample_i    (sample_i),
    .is_flush_i  (is_flush_i),
    .full_o      (full),
    .w_i         (w),
    .wp1_i       (wp1),
    .wm1_i       (wm1),
    .h_i         (h),
    .hm1_i       (hm1),
    .qcount_i    (qcount),
    .win_valid_o (win_valid),
    .win_o       (win_in)
  );

  dls_fifo #(
    .WIDTH ($bits(win_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_win_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (win_valid),
    .wdata_i (win_in),
    .pop_i   (win_pop),
    .rdata_o (win_out),
    .empty_o (win_empty),
    .count_o (qcount)
  );

  dls_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coef_i          (coef),
    .win_empty_i     (win_empty),
    .win_i           (win_out),
    .win_pop_o       (win_pop),
    .empty           (empty),
    .pop             (pop),
    .value_o         (value_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
